/* design/tle_pkg.sv */
// Shared types and constants for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

	// Prompt width and its value after reset
	localparam int PROMPT_W = 6;
	localparam logic [PROMPT_W-1:0] PROMPT_RESET = 6'd8;

	// Received key codes
	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_CANCEL = 8'h03;
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_TAB    = 8'h09;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_KILL   = 8'h15;
	localparam logic [7:0] KEY_WERASE = 8'h17;
	localparam logic [7:0] KEY_DEL    = 8'h7F;
	localparam logic [7:0] KEY_SPACE  = 8'h20;

	// Result actions
	typedef enum logic [2:0] {
		ACT_ECHO   = 3'd0,
		ACT_SPACES = 3'd1,
		ACT_ERASE  = 3'd2,
		ACT_BELL   = 3'd3,
		ACT_DONE   = 3'd4,
		ACT_CANCEL = 3'd5
	} action_t;

	// Classified key commands
	typedef enum logic [2:0] {
		CMD_CHAR,
		CMD_TAB,
		CMD_DONE,
		CMD_CANCEL,
		CMD_KILL,
		CMD_BS,
		CMD_WERASE
	} cmd_t;

	// One classified word in the command queue
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] key;
	} cmd_word_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

endpackage

/* design/tle_front.sv */
// Front end: accepts key words, drops NUL and classifies the rest.
`timescale 1ns / 1ps

module tle_front (
	input  logic                   key_valid,
	output logic                   key_stall,
	input  logic [7:0]             key_byte,
	input  tle_pkg::queue_status_t queue_status,
	output logic                   push,
	output tle_pkg::cmd_word_t     push_word
);

	tle_pkg::cmd_t cmd;
	logic          keep;

	// Map the key byte to a command
	always_comb begin
		cmd  = tle_pkg::CMD_CHAR;
		keep = 1'b1;
		unique case (key_byte)
			tle_pkg::KEY_CR, tle_pkg::KEY_LF: cmd = tle_pkg::CMD_DONE;
			tle_pkg::KEY_CANCEL:              cmd = tle_pkg::CMD_CANCEL;
			tle_pkg::KEY_KILL:                cmd = tle_pkg::CMD_KILL;
			tle_pkg::KEY_WERASE:              cmd = tle_pkg::CMD_WERASE;
			tle_pkg::KEY_BS, tle_pkg::KEY_DEL: cmd = tle_pkg::CMD_BS;
			tle_pkg::KEY_TAB:                 cmd = tle_pkg::CMD_TAB;
			tle_pkg::KEY_NUL:                 keep = 1'b0;
			default:                          cmd = tle_pkg::CMD_CHAR;
		endcase
	end

	// Stall while the queue is full; NUL is swallowed here
	assign key_stall     = queue_status.full;
	assign push          = key_valid && !queue_status.full && keep;
	assign push_word.cmd = cmd;
	assign push_word.key = key_byte;

endmodule

/* design/tle_queue.sv */
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module tle_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tle_pkg::cmd_word_t     push_word,
	input  logic                   pop,
	output tle_pkg::cmd_word_t     pop_word,
	output tle_pkg::queue_status_t status
);

	tle_pkg::cmd_word_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fill_q;

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			priority if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	assign pop_word         = entry_q[rd_ptr_q];
	assign status.full      = (fill_q == 2'd2);
	assign status.not_empty = (fill_q != 2'd0);

endmodule

/* design/tle_back.sv */
// Back end: executes edit commands on the line store and registers results.
`timescale 1ns / 1ps

module tle_back #(
	parameter int LINE_BUFFER_SIZE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tle_pkg::PROMPT_W-1:0]  prompt_length,
	input  tle_pkg::queue_status_t        queue_status,
	input  tle_pkg::cmd_word_t            cmd_word,
	output logic                          cmd_pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [2:0]                    action,
	output logic [7:0]                    echo_char,
	output logic [13:0]                   run_count,
	output logic [9:0]                    line_length,
	output logic [13:0]                   cursor_column
);

	localparam int AddrW    = $clog2(LINE_BUFFER_SIZE);
	localparam int ColW     = $clog2(63 + 8 * LINE_BUFFER_SIZE + 1);
	localparam int Capacity = LINE_BUFFER_SIZE - 2;
	localparam int RunOutW  = 14;
	localparam int LenOutW  = 10;
	localparam int ColOutW  = 14;

	// Line characters and the column before each one
	logic [7:0]      store_mem [LINE_BUFFER_SIZE];
	logic [ColW-1:0] colb_mem  [LINE_BUFFER_SIZE];

	tle_pkg::back_state_t state_q, state_d;
	logic [AddrW-1:0] count_q, count_d;
	logic [ColW-1:0]  column_q, column_d;
	logic             werase_q, werase_d;
	logic [7:0]       store_rd_q;
	logic [ColW-1:0]  colb_rd_q;

	logic             mem_we;
	logic             rd_en;
	logic [AddrW-1:0] rd_addr;

	logic             emit;
	tle_pkg::action_t act_d;
	logic [7:0]       char_d;
	logic [ColW-1:0]  run_d;
	logic [AddrW-1:0] len_d;
	logic [ColW-1:0]  col_d;

	logic             res_valid_q;

	// Shared decisions
	logic            out_free;
	logic            take;
	logic            is_delete;
	logic            walk_more;
	logic [ColW-1:0] prompt_col;
	logic            past_prompt;
	logic [3:0]      tab_run;
	logic            full;

	assign out_free    = !res_valid_q || !result_stall;
	assign take        = queue_status.not_empty && out_free && (state_q == tle_pkg::BK_IDLE);
	assign is_delete   = (cmd_word.cmd == tle_pkg::CMD_BS) ||
	                     (cmd_word.cmd == tle_pkg::CMD_WERASE);
	assign walk_more   = werase_q && (store_rd_q != tle_pkg::KEY_SPACE) && (count_q != '0);
	assign prompt_col  = ColW'(prompt_length);
	assign past_prompt = column_q > prompt_col;
	assign tab_run     = 4'd8 - {1'b0, column_q[2:0]};
	assign full        = count_q >= AddrW'(Capacity);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tle_pkg::BK_IDLE: begin
				if (take && is_delete && (count_q != '0)) state_d = tle_pkg::BK_WALK;
			end
			tle_pkg::BK_WALK: begin
				if (!walk_more && out_free) state_d = tle_pkg::BK_IDLE;
			end
			default: state_d = tle_pkg::BK_IDLE;
		endcase
	end

	// Command execution and result formation
	always_comb begin
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		act_d    = tle_pkg::ACT_ECHO;
		char_d   = 8'd0;
		run_d    = '0;
		len_d    = count_q;
		col_d    = column_q;
		count_d  = count_q;
		column_d = column_q;
		werase_d = werase_q;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = count_q - 1'b1;
		unique case (state_q)
			tle_pkg::BK_IDLE: begin
				if (take) begin
					cmd_pop = 1'b1;
					unique case (cmd_word.cmd)
						tle_pkg::CMD_DONE: begin
							emit     = 1'b1;
							act_d    = tle_pkg::ACT_DONE;
							count_d  = '0;
							column_d = prompt_col;
						end
						tle_pkg::CMD_CANCEL: begin
							emit     = 1'b1;
							act_d    = tle_pkg::ACT_CANCEL;
							len_d    = '0;
							count_d  = '0;
							column_d = prompt_col;
						end
						tle_pkg::CMD_KILL: begin
							// Nothing to erase on an empty line at the prompt
							if (past_prompt || (count_q != '0)) begin
								emit     = 1'b1;
								act_d    = tle_pkg::ACT_ERASE;
								run_d    = past_prompt ? column_q - prompt_col : '0;
								len_d    = '0;
								col_d    = past_prompt ? prompt_col : column_q;
								count_d  = '0;
								column_d = col_d;
							end
						end
						tle_pkg::CMD_BS, tle_pkg::CMD_WERASE: begin
							// Drop the last character; the walk finishes the erase
							if (count_q != '0) begin
								rd_en    = 1'b1;
								count_d  = count_q - 1'b1;
								werase_d = (cmd_word.cmd == tle_pkg::CMD_WERASE);
							end
						end
						tle_pkg::CMD_TAB, tle_pkg::CMD_CHAR: begin
							emit = 1'b1;
							if (full) begin
								act_d = tle_pkg::ACT_BELL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + 1'b1;
								len_d   = count_d;
								if (cmd_word.cmd == tle_pkg::CMD_TAB) begin
									act_d = tle_pkg::ACT_SPACES;
									run_d = ColW'(tab_run);
									col_d = column_q + ColW'(tab_run);
								end else begin
									act_d  = tle_pkg::ACT_ECHO;
									char_d = cmd_word.key;
									col_d  = column_q + 1'b1;
								end
								column_d = col_d;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			tle_pkg::BK_WALK: begin
				priority if (walk_more) begin
					// Keep dropping until a space goes or the line is empty
					rd_en   = 1'b1;
					count_d = count_q - 1'b1;
				end else if (out_free) begin
					emit     = 1'b1;
					act_d    = tle_pkg::ACT_ERASE;
					run_d    = (column_q > colb_rd_q) ? column_q - colb_rd_q : '0;
					col_d    = colb_rd_q;
					column_d = colb_rd_q;
				end
			end
			default: ;
		endcase
	end

	// Line memories: write on append, registered read while walking back
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[count_q] <= cmd_word.key;
			colb_mem[count_q]  <= column_q;
		end
		if (rd_en) begin
			store_rd_q <= store_mem[rd_addr];
			colb_rd_q  <= colb_mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tle_pkg::BK_IDLE;
			count_q     <= '0;
			column_q    <= ColW'(tle_pkg::PROMPT_RESET);
			werase_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			column_q <= column_d;
			werase_q <= werase_d;
			priority if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit) begin
			action        <= act_d;
			echo_char     <= char_d;
			run_count     <= RunOutW'(run_d);
			line_length   <= LenOutW'(len_d);
			cursor_column <= ColOutW'(col_d);
		end
	end

	assign result_valid = res_valid_q;

endmodule

/* design/terminal_line_editor.sv */
// Top level of the terminal line editor: prompt register, front, queue and back.
// A result is registered in the cycle after its key word is accepted into an idle back end;
// a delete first reads the dropped character back through the line memory read port, and
// a word erase walks back over stored characters until a space goes or the line is empty.
// Throughput: one key word a cycle for other keys when not stalled; NUL gives no result.
// Reset clears the line count, sets the column and prompt to 8 columns and empties
// the queue; the line memories are not cleared, no entry is read before written.
`timescale 1ns / 1ps

module terminal_line_editor #(
	parameter int LINE_BUFFER_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_enable,
	input  logic [5:0]  write_data,
	input  logic        key_valid,
	output logic        key_stall,
	input  logic [7:0]  key_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  action,
	output logic [7:0]  echo_char,
	output logic [13:0] run_count,
	output logic [9:0]  line_length,
	output logic [13:0] cursor_column
);

	logic [tle_pkg::PROMPT_W-1:0] prompt_q;
	tle_pkg::queue_status_t       queue_status;
	tle_pkg::cmd_word_t           push_word;
	tle_pkg::cmd_word_t           pop_word;
	logic                         push;
	logic                         pop;

	// Hold the prompt length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prompt_q <= tle_pkg::PROMPT_RESET;
		end else if (write_enable) begin
			prompt_q <= write_data;
		end
	end

	tle_front u_front (
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_byte     (key_byte),
		.queue_status (queue_status),
		.push         (push),
		.push_word    (push_word)
	);

	tle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.status    (queue_status)
	);

	tle_back #(
		.LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.prompt_length (prompt_q),
		.queue_status  (queue_status),
		.cmd_word      (pop_word),
		.cmd_pop       (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.action        (action),
		.echo_char     (echo_char),
		.run_count     (run_count),
		.line_length   (line_length),
		.cursor_column (cursor_column)
	);

endmodule

/* design/tle_checker.sv */
// Port-level checks for the terminal line editor, bound to the top level.
`timescale 1ns / 1ps

module tle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [2:0]  action,
	input logic [7:0]  echo_char,
	input logic [13:0] run_count,
	input logic [9:0]  line_length,
	input logic [13:0] cursor_column
);

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(action) &&
		$stable(echo_char) && $stable(run_count) && $stable(line_length) &&
		$stable(cursor_column))
	else $error("stalled result word changed");

	// Tab expansion ends on a tab stop and spans one to eight columns
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (action == tle_pkg::ACT_SPACES) |->
		(run_count != 14'd0) && (run_count <= 14'd8) && (cursor_column[2:0] == 3'd0))
	else $error("tab run off the tab stop");

	// Only echo carries a character; only spaces and erase carry a run
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (action != tle_pkg::ACT_ECHO) |->
		(echo_char == 8'd0) && ((action == tle_pkg::ACT_SPACES) ||
		(action == tle_pkg::ACT_ERASE) || (run_count == 14'd0)))
	else $error("stray character or run in result");

	// Cancel leaves an empty line
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (action == tle_pkg::ACT_CANCEL) |-> (line_length == 10'd0))
	else $error("cancel with nonzero line length");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.action        (action),
	.echo_char     (echo_char),
	.run_count     (run_count),
	.line_length   (line_length),
	.cursor_column (cursor_column)
);
